[hw/rtl/hsv_pkg.sv]
// Shared types, constants and helper functions for the humidity sample validator.
// No dependencies; imported by every module of the block but hsv_fifo.
package hsv_pkg;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 1'b1;

  localparam logic [31:0] STALE_RESET    = 32'd60000;
  localparam logic [15:0] INTERVAL_RESET = 16'd500;

  localparam logic [7:0]  CRC_POLY   = 8'h31;
  localparam logic [7:0]  CRC_INIT   = 8'hFF;
  localparam logic [31:0] TEMP_SCALE = 32'd17500;
  localparam logic [31:0] HUM_SCALE  = 32'd10000;
  localparam logic [31:0] ROUND_BIAS = 32'd32767;
  localparam logic [16:0] DIV_CONST  = 17'd65535;
  localparam logic signed [16:0] TEMP_OFFSET = 17'sd4500;
  localparam logic [13:0] HUM_MAX    = 14'd10000;

  localparam logic [1:0] SRC_FRESH    = 2'd0;
  localparam logic [1:0] SRC_LIMITED  = 2'd1;
  localparam logic [1:0] SRC_FALLBACK = 2'd2;
  localparam logic [1:0] SRC_NONE     = 2'd3;

  // classified request, front to back
  typedef struct packed {
    logic [31:0]        now_ms;
    logic               bus_ok;
    logic               crc_ok;
    logic signed [14:0] temp;
    logic [13:0]        hum;
  } hsv_item_t;

  typedef struct packed {
    logic               valid_res;
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;
    logic [31:0]        age_ms;
    logic [31:0]        stamp_ms;
    logic [1:0]         source;
    logic               attempted;
    logic [31:0]        errors;
  } hsv_res_t;

  // one byte of CRC-8, MSB first
  function automatic logic [7:0] crc_byte(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    for (int k = 0; k < 8; k++) begin
      r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
    end
    return r;
  endfunction

  // floor(x / 65535) for x below 2^31: x = q0*65535 + (q0 + lo), remainder < 2*65535
  function automatic logic [15:0] div_65535(input logic [30:0] x);
    logic [14:0] q0;
    logic [16:0] r;
    q0 = x[30:16];
    r  = {1'b0, x[15:0]} + {2'b00, q0};
    return {1'b0, q0} + ((r >= DIV_CONST) ? 16'd1 : 16'd0);
  endfunction

endpackage

[hw/rtl/hsv_fifo.sv]
// Small first-word-fall-through queue built from registers.
// Depends on nothing; used between front and back and on the result side.
module hsv_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("fifo push while full");
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH)) else $error("fifo count beyond depth");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && !(pop && !empty)) |=> count_r == $past(count_r) + 1'b1)
    else $error("fifo count did not advance on lone push");
`endif

endmodule

[hw/rtl/hsv_front.sv]
// Front end: two-stage pipeline that checks both CRC bytes and scales the raw words.
// Depends on hsv_pkg; feeds classified requests into the middle queue.
module hsv_front
  import hsv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  logic [31:0] in_now_ms,
  input  logic      in_bus_ok,
  input  logic [7:0] in_temp_hi,
  input  logic [7:0] in_temp_lo,
  input  logic [7:0] in_temp_check,
  input  logic [7:0] in_hum_hi,
  input  logic [7:0] in_hum_lo,
  input  logic [7:0] in_hum_check,
  output logic      item_push,
  output hsv_item_t item,
  input  logic      item_full
);

  logic        s1_v_r, s2_v_r;
  logic        s1_ready, s2_ready;

  // stage 1: first CRC byte, scale multiply with rounding bias
  logic [31:0] s1_now_r;
  logic        s1_bus_r;
  logic [7:0]  s1_t_crc_r, s1_h_crc_r;
  logic [7:0]  s1_t_lo_r, s1_h_lo_r;
  logic [7:0]  s1_t_chk_r, s1_h_chk_r;
  logic [30:0] s1_t_acc_r, s1_h_acc_r;
  logic [30:0] t_acc_nxt, h_acc_nxt;

  // stage 2: CRC finish, divide by 65535, offset and clamp
  hsv_item_t   s2_item_r, s2_item_nxt;
  logic [15:0] t_q, h_q;
  logic signed [16:0] t_s;

  assign s2_ready  = !s2_v_r || !item_full;
  assign s1_ready  = !s1_v_r || s2_ready;
  assign in_full   = !s1_ready;
  assign item_push = s2_v_r && !item_full;
  assign item      = s2_item_r;

  assign t_acc_nxt = 31'(32'({in_temp_hi, in_temp_lo}) * TEMP_SCALE + ROUND_BIAS);
  assign h_acc_nxt = 31'(32'({in_hum_hi, in_hum_lo}) * HUM_SCALE + ROUND_BIAS);

  always_comb begin
    t_q = div_65535(s1_t_acc_r);
    h_q = div_65535(s1_h_acc_r);
    t_s = $signed({1'b0, t_q}) - TEMP_OFFSET;
    s2_item_nxt.now_ms = s1_now_r;
    s2_item_nxt.bus_ok = s1_bus_r;
    s2_item_nxt.crc_ok = (crc_byte(s1_t_crc_r ^ s1_t_lo_r) == s1_t_chk_r) &&
                         (crc_byte(s1_h_crc_r ^ s1_h_lo_r) == s1_h_chk_r);
    s2_item_nxt.temp   = t_s[14:0];
    s2_item_nxt.hum    = (h_q > {2'b00, HUM_MAX}) ? HUM_MAX : h_q[13:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= in_push;
      end
      if (s2_ready) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_now_r   <= in_now_ms;
      s1_bus_r   <= in_bus_ok;
      s1_t_crc_r <= crc_byte(CRC_INIT ^ in_temp_hi);
      s1_h_crc_r <= crc_byte(CRC_INIT ^ in_hum_hi);
      s1_t_lo_r  <= in_temp_lo;
      s1_h_lo_r  <= in_hum_lo;
      s1_t_chk_r <= in_temp_check;
      s1_h_chk_r <= in_hum_check;
      s1_t_acc_r <= t_acc_nxt;
      s1_h_acc_r <= h_acc_nxt;
    end
    if (s2_ready) begin
      s2_item_r <= s2_item_nxt;
    end
  end

endmodule

[hw/rtl/hsv_back.sv]
// Back end: rate limit, cache and error count; one request retired per cycle while
// there is one to read and room to write. Depends on hsv_pkg; reads the middle queue, writes the result queue.
module hsv_back
  import hsv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  hsv_item_t            item,
  input  logic                 item_empty,
  output logic                 item_pop,
  output logic                 res_push,
  output hsv_res_t             res,
  input  logic                 res_full
);

  logic [31:0]        stale_r;
  logic [15:0]        interval_r;
  logic [31:0]        last_attempt_r, last_attempt_nxt;
  logic [31:0]        last_good_r, last_good_nxt;
  logic               have_r, have_nxt;
  logic signed [14:0] temp_r, temp_nxt;
  logic [13:0]        hum_r, hum_nxt;
  logic [31:0]        fail_cnt_r, fail_cnt_nxt;

  logic        go;
  logic [31:0] elapsed, age_c;
  logic        limited, good;

  assign go       = !item_empty && !res_full;
  assign item_pop = go;
  assign res_push = go;

  assign elapsed = item.now_ms - last_attempt_r;
  assign age_c   = item.now_ms - last_good_r;
  assign limited = (last_attempt_r != '0) && (elapsed < {16'd0, interval_r});
  assign good    = item.bus_ok && item.crc_ok;

  always_comb begin
    last_attempt_nxt = last_attempt_r;
    last_good_nxt    = last_good_r;
    have_nxt         = have_r;
    temp_nxt         = temp_r;
    hum_nxt          = hum_r;
    fail_cnt_nxt     = fail_cnt_r;

    res.valid_res         = 1'b0;
    res.temperature_centi = '0;
    res.humidity_centi    = '0;
    res.age_ms            = '1;
    res.stamp_ms          = item.now_ms;
    res.source            = SRC_NONE;
    res.attempted         = 1'b0;

    if (limited) begin
      if (have_r) begin
        res.valid_res         = 1'b1;
        res.source            = SRC_LIMITED;
        res.temperature_centi = temp_r;
        res.humidity_centi    = hum_r;
        res.age_ms            = age_c;
      end
    end else begin
      last_attempt_nxt = item.now_ms;
      res.attempted    = item.bus_ok;
      if (good) begin
        temp_nxt              = item.temp;
        hum_nxt               = item.hum;
        have_nxt              = 1'b1;
        last_good_nxt         = item.now_ms;
        res.valid_res         = 1'b1;
        res.source            = SRC_FRESH;
        res.temperature_centi = item.temp;
        res.humidity_centi    = item.hum;
        res.age_ms            = '0;
      end else begin
        fail_cnt_nxt = fail_cnt_r + 32'd1;
        if (have_r) begin
          res.age_ms = age_c;
          if (age_c <= stale_r) begin
            res.valid_res         = 1'b1;
            res.source            = SRC_FALLBACK;
            res.temperature_centi = temp_r;
            res.humidity_centi    = hum_r;
          end
        end
      end
    end
    res.errors = fail_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stale_r        <= STALE_RESET;
      interval_r     <= INTERVAL_RESET;
      last_attempt_r <= '0;
      last_good_r    <= '0;
      have_r         <= 1'b0;
      temp_r         <= '0;
      hum_r          <= '0;
      fail_cnt_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_STALE:    stale_r    <= cfg_data;
          CFG_INTERVAL: interval_r <= cfg_data[15:0];
          default:      ;
        endcase
      end
      if (go) begin
        last_attempt_r <= last_attempt_nxt;
        last_good_r    <= last_good_nxt;
        have_r         <= have_nxt;
        temp_r         <= temp_nxt;
        hum_r          <= hum_nxt;
        fail_cnt_r     <= fail_cnt_nxt;
      end
    end
  end

`ifndef SYNTHESIS
  a_fresh_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res.source == SRC_FRESH) |-> (res.valid_res && res.attempted))
    else $error("fresh result without a checked read");
  a_invalid_none: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && !res.valid_res) |-> res.source == SRC_NONE)
    else $error("invalid result with a cache source");
  a_err_step: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> (fail_cnt_r == $past(fail_cnt_r) || fail_cnt_r == $past(fail_cnt_r) + 32'd1))
    else $error("error count moved by more than one");
`endif

endmodule

[hw/rtl/humidity_sample_validator_cache.sv]
// A transferred request passes the two front stages, the middle queue and the result
// queue before it shows on the out ports and can be popped.
// Throughput: one request per cycle while results are popped, as the back end retires one per cycle.
// Reset: synchronous, active low; clears queues and cache, errors count to zero,
// stale timeout to 60000 ms and minimum interval to 500 ms. No clearing pass.
module humidity_sample_validator_cache
  import hsv_pkg::*;
#(
  parameter int MID_DEPTH = 2,
  parameter int OUT_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [31:0]          in_now_ms,
  input  logic                 in_bus_ok,
  input  logic [7:0]           in_temp_hi,
  input  logic [7:0]           in_temp_lo,
  input  logic [7:0]           in_temp_check,
  input  logic [7:0]           in_hum_hi,
  input  logic [7:0]           in_hum_lo,
  input  logic [7:0]           in_hum_check,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic                 out_valid_res,
  output logic signed [14:0]   out_temperature_centi,
  output logic [13:0]          out_humidity_centi,
  output logic [31:0]          out_age_ms,
  output logic [31:0]          out_stamp_ms,
  output logic [1:0]           out_source,
  output logic                 out_attempted,
  output logic [31:0]          out_errors
);

  localparam int IW = $bits(hsv_item_t);
  localparam int RW = $bits(hsv_res_t);

  hsv_item_t      fe_item, be_item;
  logic           fe_push, mid_full, mid_empty, mid_pop;
  logic [IW-1:0]  mid_dout;
  hsv_res_t       be_res, out_res;
  logic           res_push, res_full;
  logic [RW-1:0]  out_dout;

  hsv_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_now_ms     (in_now_ms),
    .in_bus_ok     (in_bus_ok),
    .in_temp_hi    (in_temp_hi),
    .in_temp_lo    (in_temp_lo),
    .in_temp_check (in_temp_check),
    .in_hum_hi     (in_hum_hi),
    .in_hum_lo     (in_hum_lo),
    .in_hum_check  (in_hum_check),
    .item_push     (fe_push),
    .item          (fe_item),
    .item_full     (mid_full)
  );

  hsv_fifo #(.WIDTH(IW), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fe_push),
    .din   (fe_item),
    .full  (mid_full),
    .pop   (mid_pop),
    .dout  (mid_dout),
    .empty (mid_empty)
  );

  assign be_item = mid_dout;

  hsv_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item       (be_item),
    .item_empty (mid_empty),
    .item_pop   (mid_pop),
    .res_push   (res_push),
    .res        (be_res),
    .res_full   (res_full)
  );

  hsv_fifo #(.WIDTH(RW), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (be_res),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (out_dout),
    .empty (out_empty)
  );

  assign out_res               = out_dout;
  assign out_valid_res         = out_res.valid_res;
  assign out_temperature_centi = out_res.temperature_centi;
  assign out_humidity_centi    = out_res.humidity_centi;
  assign out_age_ms            = out_res.age_ms;
  assign out_stamp_ms          = out_res.stamp_ms;
  assign out_source            = out_res.source;
  assign out_attempted         = out_res.attempted;
  assign out_errors            = out_res.errors;

endmodule

[verif/tb.sv]
// Self-checking testbench for humidity_sample_validator_cache: directed and random sensor polls.
// Depends on hsv_pkg and the block RTL; a scoreboard class predicts every result from the
// accepted requests and the register settings.
import hsv_pkg::*;

typedef struct {
  logic [31:0] now_ms;
  logic        bus_ok;
  logic [7:0]  temp_hi;
  logic [7:0]  temp_lo;
  logic [7:0]  temp_check;
  logic [7:0]  hum_hi;
  logic [7:0]  hum_lo;
  logic [7:0]  hum_check;
} sensor_req_t;

// CRC-8 over one 16-bit word, fed MSB first
function automatic logic [7:0] crc8_word(input logic [7:0] hi, input logic [7:0] lo);
  logic [7:0]  crc;
  logic [15:0] word;
  int          i;
  crc = CRC_INIT;
  word = {hi, lo};
  for (i = 15; i >= 0; i--) begin
    if (crc[7] ^ word[i]) begin
      crc = {crc[6:0], 1'b0} ^ CRC_POLY;
    end else begin
      crc = {crc[6:0], 1'b0};
    end
  end
  return crc;
endfunction

class sample_scoreboard;
  logic [31:0]        stale_timeout;
  logic [15:0]        min_interval;
  logic [31:0]        last_attempt;
  logic [31:0]        last_good;
  logic [31:0]        failure_count;
  logic               have_sample;
  logic signed [14:0] cached_temp;
  logic [13:0]        cached_hum;
  hsv_res_t           expected_q[$];
  int                 mismatches;
  logic [31:0]        at_stamp;

  function new();
    stale_timeout = STALE_RESET;
    min_interval  = INTERVAL_RESET;
    last_attempt  = '0;
    last_good     = '0;
    failure_count = '0;
    have_sample   = 1'b0;
    cached_temp   = '0;
    cached_hum    = '0;
    mismatches    = 0;
    at_stamp      = '0;
  endfunction

  function void write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    if (idx == CFG_STALE) begin
      stale_timeout = data;
    end else begin
      min_interval = data[15:0];
    end
  endfunction

  // predicts the result of one transferred request and updates the cache
  function void note_request(input sensor_req_t r);
    hsv_res_t    res;
    logic [31:0] since_attempt;
    logic [31:0] tc;
    logic [31:0] hc;
    int          temp_int;
    res.valid_res         = 1'b0;
    res.temperature_centi = '0;
    res.humidity_centi    = '0;
    res.age_ms            = '1;
    res.stamp_ms          = r.now_ms;
    res.source            = SRC_NONE;
    res.attempted         = 1'b0;
    since_attempt = r.now_ms - last_attempt;
    if (last_attempt != 0 && since_attempt < {16'd0, min_interval}) begin
      if (have_sample) begin
        res.valid_res         = 1'b1;
        res.source            = SRC_LIMITED;
        res.temperature_centi = cached_temp;
        res.humidity_centi    = cached_hum;
        res.age_ms            = r.now_ms - last_good;
      end
    end else begin
      last_attempt  = r.now_ms;
      res.attempted = r.bus_ok;
      if (r.bus_ok && crc8_word(r.temp_hi, r.temp_lo) == r.temp_check &&
          crc8_word(r.hum_hi, r.hum_lo) == r.hum_check) begin
        tc = (32'd17500 * {16'd0, r.temp_hi, r.temp_lo} + 32'd32767) / 32'd65535;
        hc = (32'd10000 * {16'd0, r.hum_hi, r.hum_lo} + 32'd32767) / 32'd65535;
        if (hc > 32'd10000) hc = 32'd10000;
        temp_int    = int'(tc) - 4500;
        cached_temp = temp_int[14:0];
        cached_hum  = hc[13:0];
        have_sample = 1'b1;
        last_good   = r.now_ms;
        res.valid_res         = 1'b1;
        res.source            = SRC_FRESH;
        res.temperature_centi = cached_temp;
        res.humidity_centi    = cached_hum;
        res.age_ms            = '0;
      end else begin
        failure_count = failure_count + 1;
        if (have_sample) begin
          res.age_ms = r.now_ms - last_good;
          if (res.age_ms <= stale_timeout) begin
            res.valid_res         = 1'b1;
            res.source            = SRC_FALLBACK;
            res.temperature_centi = cached_temp;
            res.humidity_centi    = cached_hum;
          end
        end
      end
    end
    res.errors = failure_count;
    expected_q.push_back(res);
  endfunction

  function void flag(input string field, input longint e, input longint a);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch on %s at stamp %0h: expected %0d, got %0d", field, at_stamp, e, a);
    end
  endfunction

  function void check_result(input hsv_res_t got);
    hsv_res_t exp_res;
    if (expected_q.size() == 0) begin
      at_stamp = got.stamp_ms;
      flag("result with nothing pending", 0, 1);
      return;
    end
    exp_res = expected_q.pop_front();
    at_stamp = exp_res.stamp_ms;
    if (got.valid_res !== exp_res.valid_res)
      flag("valid_res", exp_res.valid_res, got.valid_res);
    if (got.temperature_centi !== exp_res.temperature_centi)
      flag("temperature_centi", exp_res.temperature_centi, got.temperature_centi);
    if (got.humidity_centi !== exp_res.humidity_centi)
      flag("humidity_centi", exp_res.humidity_centi, got.humidity_centi);
    if (got.age_ms !== exp_res.age_ms)
      flag("age_ms", exp_res.age_ms, got.age_ms);
    if (got.stamp_ms !== exp_res.stamp_ms)
      flag("stamp_ms", exp_res.stamp_ms, got.stamp_ms);
    if (got.source !== exp_res.source)
      flag("source", exp_res.source, got.source);
    if (got.attempted !== exp_res.attempted)
      flag("attempted", exp_res.attempted, got.attempted);
    if (got.errors !== exp_res.errors)
      flag("errors", exp_res.errors, got.errors);
  endfunction
endclass

module tb;
  localparam int CYCLE_LIMIT = 300000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_STALE;
  logic [31:0]          cfg_data = '0;
  logic                 in_push = 1'b0;
  logic                 in_full;
  logic [31:0]          in_now_ms = '0;
  logic                 in_bus_ok = 1'b0;
  logic [7:0]           in_temp_hi = '0;
  logic [7:0]           in_temp_lo = '0;
  logic [7:0]           in_temp_check = '0;
  logic [7:0]           in_hum_hi = '0;
  logic [7:0]           in_hum_lo = '0;
  logic [7:0]           in_hum_check = '0;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  logic                 out_valid_res;
  logic signed [14:0]   out_temperature_centi;
  logic [13:0]          out_humidity_centi;
  logic [31:0]          out_age_ms;
  logic [31:0]          out_stamp_ms;
  logic [1:0]           out_source;
  logic                 out_attempted;
  logic [31:0]          out_errors;

  sample_scoreboard sb;
  hsv_res_t         got;
  logic [31:0]      clock_ms = '0;
  int               cycles = 0;
  int               pop_hold = 0;
  bit               pop_bursty = 1'b1;
  bit               send_bursty = 1'b1;
  bit               quiet_end = 1'b0;

  humidity_sample_validator_cache uut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: check each transfer, stall in random bursts
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      got.valid_res         = out_valid_res;
      got.temperature_centi = out_temperature_centi;
      got.humidity_centi    = out_humidity_centi;
      got.age_ms            = out_age_ms;
      got.stamp_ms          = out_stamp_ms;
      got.source            = out_source;
      got.attempted         = out_attempted;
      got.errors            = out_errors;
      sb.check_result(got);
    end
    if (pop_hold > 0) begin
      out_pop <= 1'b0;
      pop_hold = pop_hold - 1;
    end else if (!quiet_end && pop_bursty && $urandom_range(0, 3) == 0) begin
      out_pop <= 1'b0;
      pop_hold = $urandom_range(0, 6);
    end else begin
      out_pop <= 1'b1;
    end
    if ($urandom_range(0, 49) == 0) pop_bursty = !pop_bursty;
  end

  function automatic sensor_req_t build(input logic [31:0] now, input logic bus,
                                        input logic [15:0] tw, input logic [15:0] hw,
                                        input logic tbad, input logic hbad);
    sensor_req_t r;
    logic [7:0]  flip_t;
    logic [7:0]  flip_h;
    flip_t = tbad ? 8'($urandom_range(1, 255)) : 8'h00;
    flip_h = hbad ? 8'($urandom_range(1, 255)) : 8'h00;
    r.now_ms     = now;
    r.bus_ok     = bus;
    r.temp_hi    = tw[15:8];
    r.temp_lo    = tw[7:0];
    r.hum_hi     = hw[15:8];
    r.hum_lo     = hw[7:0];
    r.temp_check = crc8_word(tw[15:8], tw[7:0]) ^ flip_t;
    r.hum_check  = crc8_word(hw[15:8], hw[7:0]) ^ flip_h;
    return r;
  endfunction

  // raw bytes with no regard for the check bytes
  function automatic sensor_req_t noise(input logic [31:0] now);
    sensor_req_t r;
    r = build(now, 1'($urandom_range(0, 1)), 16'($urandom_range(0, 16'hFFFF)),
              16'($urandom_range(0, 16'hFFFF)), 1'b0, 1'b0);
    r.temp_check = 8'($urandom_range(0, 255));
    r.hum_check  = 8'($urandom_range(0, 255));
    return r;
  endfunction

  function automatic logic [15:0] rand_word();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  // time steps cluster around the rate limit; content is mostly well-formed
  function automatic sensor_req_t next_request();
    int unsigned iv;
    logic [15:0] tw;
    logic [15:0] hw;
    int          pick;
    iv = sb.min_interval;
    case ($urandom_range(0, 15))
      0, 1, 2: clock_ms += $urandom_range(0, iv);
      3:       clock_ms += iv;
      11:      clock_ms += $urandom_range(0, 200000);
      12:      clock_ms = sb.last_good + sb.stale_timeout + $urandom_range(0, 2) - 1;
      13:      clock_ms = $urandom;
      14:      clock_ms = 32'd0;
      15:      clock_ms += iv + $urandom_range(0, 65535);
      default: clock_ms += iv + $urandom_range(0, 300);
    endcase
    tw = rand_word();
    hw = rand_word();
    pick = $urandom_range(0, 15);
    if (pick <= 9) return build(clock_ms, 1'b1, tw, hw, 1'b0, 1'b0);
    if (pick == 10) begin
      return build(clock_ms, 1'b0, tw, hw, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    if (pick <= 13) return build(clock_ms, 1'b1, tw, hw, pick != 12, pick != 11);
    return noise(clock_ms);
  endfunction

  task automatic send_request(input sensor_req_t r);
    in_push       <= 1'b1;
    in_now_ms     <= r.now_ms;
    in_bus_ok     <= r.bus_ok;
    in_temp_hi    <= r.temp_hi;
    in_temp_lo    <= r.temp_lo;
    in_temp_check <= r.temp_check;
    in_hum_hi     <= r.hum_hi;
    in_hum_lo     <= r.hum_lo;
    in_hum_check  <= r.hum_check;
    do @(posedge clk); while (in_full !== 1'b0);
    sb.note_request(r);
    if ($urandom_range(0, 39) == 0) send_bursty = !send_bursty;
    if (!quiet_end && send_bursty && $urandom_range(0, 2) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // hold off until every expected result has been popped
  task automatic wait_drained();
    in_push <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(input logic [31:0] stale, input logic [15:0] interval);
    logic [31:0] interval_word;
    interval_word = {16'($urandom_range(0, 16'hFFFF)), interval};
    cfg_we    <= 1'b1;
    cfg_index <= CFG_STALE;
    cfg_data  <= stale;
    @(posedge clk);
    cfg_index <= CFG_INTERVAL;
    cfg_data  <= interval_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_register(CFG_STALE, stale);
    sb.write_register(CFG_INTERVAL, interval_word);
    @(posedge clk);
  endtask

  task automatic run_phase(input logic [31:0] stale, input logic [15:0] interval,
                           input int count, input bit calm_tail);
    int n;
    wait_drained();
    configure(stale, interval);
    for (n = 0; n < count; n++) begin
      if (calm_tail && n == count / 2) quiet_end = 1'b1;
      send_request(next_request());
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    configure(STALE_RESET, INTERVAL_RESET);

    // bus failure at time zero with nothing cached
    send_request(build(32'd0, 1'b0, rand_word(), rand_word(), 1'b0, 1'b0));
    // zero attempt time never rate-limits; smallest raw words
    send_request(build(32'd10, 1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0));
    send_request(build(32'd200, 1'b1, 16'h1111, 16'h2222, 1'b0, 1'b0));
    // exactly one interval later; largest raw words
    send_request(build(32'd510, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0));
    send_request(build(32'd1009, 1'b1, 16'h1234, 16'h5678, 1'b0, 1'b0));
    send_request(build(32'd1010, 1'b0, 16'h1234, 16'h5678, 1'b0, 1'b0));
    send_request(build(32'd1600, 1'b1, 16'h4321, 16'h8765, 1'b1, 1'b0));
    send_request(build(32'd2200, 1'b1, 16'h4321, 16'h8765, 1'b0, 1'b1));
    send_request(build(32'd2800, 1'b1, 16'h4321, 16'h8765, 1'b1, 1'b1));
    // cache age right at the stale timeout, then just past it
    send_request(build(32'd60510, 1'b0, 16'h0, 16'h0, 1'b0, 1'b0));
    send_request(build(32'd61011, 1'b0, 16'h0, 16'h0, 1'b0, 1'b0));
    // time wraps around zero
    send_request(build(32'hFFFF_FF00, 1'b1, 16'h8000, 16'h8000, 1'b0, 1'b0));
    send_request(build(32'h0000_0010, 1'b1, 16'h8000, 16'h8000, 1'b0, 1'b0));
    send_request(build(32'h0000_0300, 1'b1, 16'h8000, 16'h8000, 1'b1, 1'b0));
    // a good read at time zero leaves the attempt time unset
    send_request(build(32'd0, 1'b1, 16'h6666, 16'h9999, 1'b0, 1'b0));
    send_request(build(32'd5, 1'b0, 16'h6666, 16'h9999, 1'b0, 1'b0));
    send_request(build(32'd6, 1'b1, 16'h6666, 16'h9999, 1'b0, 1'b0));
    send_request(build(32'd700, 1'b1, 16'h7FFF, 16'h8000, 1'b0, 1'b0));
    send_request(build(32'd1300, 1'b1, 16'h0001, 16'hFFFE, 1'b0, 1'b0));
    send_request(noise(32'd1900));
    clock_ms = 32'd1900;

    run_phase(32'd0, 16'd0, 250, 1'b0);
    run_phase(32'hFFFF_FFFF, 16'hFFFF, 250, 1'b0);
    run_phase(32'd1000, 16'd100, 300, 1'b0);
    run_phase($urandom, 16'($urandom_range(0, 2000)), 300, 1'b0);
    run_phase(32'd60000, 16'd1, 300, 1'b0);
    run_phase(32'd5000, 16'd500, 300, 1'b1);

    wait_drained();
    repeat (12) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

[sim.f]
hw/rtl/hsv_pkg.sv
hw/rtl/hsv_fifo.sv
hw/rtl/hsv_front.sv
hw/rtl/hsv_back.sv
hw/rtl/humidity_sample_validator_cache.sv
verif/tb.sv
